// File: design/lz4d_pkg.sv
// Shared types and constants for the LZ4 block decoder.
package lz4d_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_DIST = 3'd1,
    ST_FAR       = 3'd2,
    ST_SIZE      = 3'd3,
    ST_OPCODE    = 3'd4,
    ST_TRUNC     = 3'd5
  } status_e;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] CFG_EXPECTED_SIZE = 2'd0;
  localparam logic [1:0] CFG_WINDOW_START  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd2;

  // One input transaction as it sits in the queue.
  typedef struct packed {
    logic       opcode;
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

endpackage

// File: design/lz4d_fifo.sv
// Two-entry queue between the input side and the decode engine.
module lz4d_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lz4d_pkg::item_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lz4d_pkg::item_t pop_data_o
);
  import lz4d_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end
endmodule

// File: design/lz4d_engine.sv
// Decode engine: parser state, history memory and result register.
module lz4d_engine #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     expected_size_i,
  input  logic [31:0]     window_start_i,
  input  logic [31:0]     window_length_i,
  input  logic            item_valid_i,
  input  lz4d_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            valid_o,
  input  logic            stall_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic [31:0]     out_position_o,
  output logic            need_tick_o,
  output logic            done_res_o,
  output logic [2:0]      status_o
);
  import lz4d_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITEXT, PH_LITERAL, PH_OFF_LO, PH_OFF_HI, PH_MATCHEXT, PH_COPY, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] lit_q, lit_d, mrem_q, mrem_d, cnt_q, cnt_d;
  logic [15:0] dist_q, dist_d;
  logic [AW-1:0] wptr_q, wptr_d;
  status_e     err_q, err_d;

  logic [7:0]  hist_q [HISTORY_DEPTH];
  logic        res_q;
  logic        ov_q, nt_q, dn_q;
  logic [7:0]  ob_q;
  logic [31:0] op_q;
  logic [2:0]  st_q;

  logic        fire, emit, wrong;
  logic [7:0]  emit_byte, hist_rd;
  logic [AW-1:0] wptr_nx;
  logic [15:0] dist_nx;
  logic [31:0] rd_sum;
  logic [AW-1:0] rd_addr;
  logic [7:0]  rd_data_q, fwd_byte_q;
  logic        fwd_hit_q;
  logic [31:0] ws, room, wl, rel;
  logic        in_win;
  logic [32:0] sum33;
  logic [15:0] dist_new;

  // Output slot frees when empty or taken this cycle.
  assign fire       = item_valid_i && (!res_q || !stall_i);
  assign item_pop_o = fire;

  // The copy source is registered at each edge, addressed from the state that
  // edge leaves behind; a byte written at that same edge is forwarded instead.
  assign wptr_nx = fire ? wptr_d : wptr_q;
  assign dist_nx = fire ? dist_d : dist_q;
  assign rd_sum  = ({16'd0, dist_nx} > 32'(wptr_nx)) ?
                   32'(wptr_nx) + 32'(HISTORY_DEPTH) - {16'd0, dist_nx} :
                   32'(wptr_nx) - {16'd0, dist_nx};
  assign rd_addr = rd_sum[AW-1:0];
  assign hist_rd = fwd_hit_q ? fwd_byte_q : rd_data_q;

  assign ws   = (window_start_i < expected_size_i) ? window_start_i : expected_size_i;
  assign room = expected_size_i - ws;
  assign wl   = (window_length_i < room) ? window_length_i : room;
  assign rel  = cnt_q - ws;
  assign in_win = (cnt_q >= ws) && (rel < wl);
  assign dist_new = {item_i.in_byte, dist_q[7:0]};

  always_comb begin
    phase_d = phase_q; lit_d = lit_q; mrem_d = mrem_q; dist_d = dist_q;
    cnt_d = cnt_q; wptr_d = wptr_q; err_d = err_q;
    emit = 1'b0; emit_byte = item_i.in_byte; wrong = 1'b0; sum33 = '0;
    if (phase_q != PH_DONE) begin
      if ((item_i.opcode == OP_TICK) != (phase_q == PH_COPY)) begin
        wrong = 1'b1;
      end else if (item_i.opcode == OP_TICK) begin
        emit = 1'b1; emit_byte = hist_rd;
        mrem_d = mrem_q - 32'd1;
        if (mrem_q == 32'd1) phase_d = PH_TOKEN;
      end else begin
        unique case (phase_q)
          PH_TOKEN: begin
            mrem_d = {28'd0, item_i.in_byte[3:0]};
            lit_d  = {28'd0, item_i.in_byte[7:4]};
            if (item_i.in_last) begin
              phase_d = PH_DONE;
              if (item_i.in_byte[7:4] != 4'd0) err_d = ST_TRUNC;
              else err_d = (cnt_q != expected_size_i) ? ST_SIZE : ST_OK;
            end else if (item_i.in_byte[7:4] == 4'hf) phase_d = PH_LITEXT;
            else if (item_i.in_byte[7:4] != 4'd0) phase_d = PH_LITERAL;
            else phase_d = PH_OFF_LO;
          end
          PH_LITEXT: begin
            sum33 = {1'b0, lit_q} + 33'(item_i.in_byte);
            lit_d = sum33[32] ? '1 : sum33[31:0];
            if (item_i.in_last) begin
              phase_d = PH_DONE; err_d = ST_TRUNC;
            end else if (item_i.in_byte != 8'hff) phase_d = PH_LITERAL;
          end
          PH_LITERAL: begin
            emit  = 1'b1;
            lit_d = lit_q - 32'd1;
            if (lit_q == 32'd1) begin
              if (item_i.in_last) begin
                phase_d = PH_DONE;
                err_d = ((cnt_q + 32'd1) != expected_size_i) ? ST_SIZE : ST_OK;
              end else phase_d = PH_OFF_LO;
            end else if (item_i.in_last) begin
              phase_d = PH_DONE; err_d = ST_TRUNC;
            end
          end
          PH_OFF_LO: begin
            dist_d = {8'd0, item_i.in_byte};
            if (item_i.in_last) begin
              phase_d = PH_DONE; err_d = ST_TRUNC;
            end else phase_d = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            dist_d = dist_new;
            if (dist_new == 16'd0) begin
              phase_d = PH_DONE; err_d = ST_ZERO_DIST;
            end else if ({16'd0, dist_new} > cnt_q || {1'b0, dist_new} > DEPTH17) begin
              phase_d = PH_DONE; err_d = ST_FAR;
            end else if (item_i.in_last) begin
              phase_d = PH_DONE; err_d = ST_TRUNC;
            end else if (mrem_q == 32'd15) phase_d = PH_MATCHEXT;
            else begin
              mrem_d = mrem_q + 32'd4; phase_d = PH_COPY;
            end
          end
          PH_MATCHEXT: begin
            sum33 = {1'b0, mrem_q} + 33'(item_i.in_byte) +
                    ((item_i.in_byte != 8'hff) ? 33'd4 : 33'd0);
            mrem_d = sum33[32] ? '1 : sum33[31:0];
            if (item_i.in_last) begin
              phase_d = PH_DONE; err_d = ST_TRUNC;
            end else if (item_i.in_byte != 8'hff) phase_d = PH_COPY;
          end
          default: begin
            phase_d = PH_DONE; err_d = ST_TRUNC;
          end
        endcase
      end
      if (emit) begin
        cnt_d = cnt_q + 32'd1;
        wptr_d = (32'(wptr_q) + 32'd1 >= 32'(HISTORY_DEPTH)) ? '0 : wptr_q + AW'(1);
      end
      if (phase_d == PH_DONE) begin
        lit_d = '0; mrem_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOKEN; lit_q <= '0; mrem_q <= '0; dist_q <= '0;
      cnt_q <= '0; wptr_q <= '0; err_q <= ST_OK; res_q <= 1'b0;
      ov_q <= 1'b0; nt_q <= 1'b0; dn_q <= 1'b0; st_q <= '0;
    end else begin
      if (fire) begin
        phase_q <= phase_d; lit_q <= lit_d; mrem_q <= mrem_d; dist_q <= dist_d;
        cnt_q <= cnt_d; wptr_q <= wptr_d; err_q <= err_d; res_q <= 1'b1;
        ov_q <= emit && in_win;
        nt_q <= (phase_d == PH_COPY);
        dn_q <= (phase_d == PH_DONE);
        st_q <= wrong ? ST_OPCODE : err_d;
      end else if (!stall_i) begin
        res_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ob_q <= emit ? emit_byte : 8'd0;
      op_q <= emit ? cnt_q : 32'd0;
    end
    if (fire && emit) hist_q[wptr_q] <= emit_byte;
    rd_data_q  <= hist_q[rd_addr];
    fwd_hit_q  <= fire && emit && (rd_addr == wptr_q);
    fwd_byte_q <= emit_byte;
  end

  assign valid_o        = res_q;
  assign out_valid_o    = ov_q;
  assign out_byte_o     = ob_q;
  assign out_position_o = op_q;
  assign need_tick_o    = nt_q;
  assign done_res_o     = dn_q;
  assign status_o       = st_q;
endmodule

// File: design/lz4_block_decoder.sv
// Top level of the LZ4 block decoder: configuration, queue and engine.
//
// Input channel: in_valid_i / in_stall_o with opcode_i, in_byte_i, in_last_i.
// opcode 0 supplies a compressed byte, opcode 1 is a tick that produces the
// next match byte. Every accepted item yields exactly one result transaction
// on res_valid_o / res_stall_i carrying out_valid_o, out_byte_o,
// out_position_o, need_tick_o, done_res_o and status_o.
// Throughput is one item per cycle while the receiver does not stall. An
// accepted item enters the two-entry queue, from which the decode stage
// loads the result register. The history memory is read with a registered
// output addressed from the state being loaded, with forwarding of the byte
// written at the same edge, so overlapping copies run back to back.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i, cfg_data_i;
// write only while the decoder is idle.
// Reset clears parser state and counters and sets window_length to all ones;
// history contents stay undefined until written.
// When the receiver stalls, the result register holds, the queue fills up
// to its two entries and then in_stall_o rises.
module lz4_block_decoder #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [31:0] out_position_o,
  output logic        need_tick_o,
  output logic        done_res_o,
  output logic [2:0]  status_o
);
  import lz4d_pkg::*;

  logic [31:0] exp_q, ws_q, wl_q;
  item_t       push_item, pop_item;
  logic        full, empty, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0; ws_q <= '0; wl_q <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EXPECTED_SIZE: exp_q <= cfg_data_i;
        CFG_WINDOW_START:  ws_q  <= cfg_data_i;
        CFG_WINDOW_LENGTH: wl_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign push_item  = '{opcode: opcode_i, in_byte: in_byte_i, in_last: in_last_i};

  lz4d_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(in_valid_i && !full), .push_data_i(push_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_item)
  );

  lz4d_engine #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_engine (
    .clk_i, .rst_ni,
    .expected_size_i(exp_q), .window_start_i(ws_q), .window_length_i(wl_q),
    .item_valid_i(!empty), .item_i(pop_item), .item_pop_o(pop),
    .valid_o(res_valid_o), .stall_i(res_stall_i),
    .out_valid_o, .out_byte_o, .out_position_o, .need_tick_o, .done_res_o, .status_o
  );
endmodule

// File: design/lz4d_checker.sv
// Port-level checker for the LZ4 block decoder, bound to the top level.
module lz4d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_stall_i,
  input logic        out_valid_o,
  input logic [7:0]  out_byte_o,
  input logic [31:0] out_position_o,
  input logic        need_tick_o,
  input logic        done_res_o,
  input logic [2:0]  status_o
);
  import lz4d_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=>
      res_valid_o && $stable(out_byte_o) && $stable(out_position_o))
    else $error("stalled result changed");
  a_done_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && done_res_o |-> !need_tick_o)
    else $error("tick request after block end");
  a_byte_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o != ST_OPCODE)
    else $error("byte produced by an ignored transaction");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> status_o <= ST_TRUNC)
    else $error("status out of range");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !done_res_o |-> status_o == ST_OK || status_o == ST_OPCODE)
    else $error("error status without block end");
endmodule

bind lz4_block_decoder lz4d_checker u_lz4d_checker (
  .clk_i, .rst_ni, .res_valid_o, .res_stall_i, .out_valid_o, .out_byte_o,
  .out_position_o, .need_tick_o, .done_res_o, .status_o
);

// File: sim/tb_top.sv
// Self-checking testbench for the LZ4 block decoder with random handshakes.
`timescale 1ns / 100ps

module tb_top;
  import lz4d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef enum logic [2:0] {
    P_TOKEN, P_LITEXT, P_LITERAL, P_OFF_LO, P_OFF_HI, P_MATCHEXT, P_COPY, P_DONE
  } parse_e;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [31:0] out_position;
    logic        need_tick;
    logic        done_res;
    logic [2:0]  status;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        opcode_i = 1'b0;
  logic [7:0]  in_byte_i = '0;
  logic        in_last_i = 1'b0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic [31:0] out_position_o;
  logic        need_tick_o;
  logic        done_res_o;
  logic [2:0]  status_o;

  lz4_block_decoder u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Decoder state mirrored by the predictor.
  logic [31:0] exp_size = 32'd0;
  logic [31:0] win_start = 32'd0;
  logic [31:0] win_len = 32'hFFFF_FFFF;
  parse_e      phase = P_TOKEN;
  logic [31:0] lit_left = '0;
  logic [31:0] match_left = '0;
  logic [15:0] distance = '0;
  logic [31:0] produced = '0;
  logic [7:0]  history [65536];
  logic [15:0] wr_ptr = '0;
  logic        ended = 1'b0;
  logic [2:0]  end_status = ST_OK;

  item_t   pending_q [$];
  result_t expected_q [$];
  int      errors = 0;
  int      items_queued = 0;
  int      decoded_bytes = 0;
  int      cycles = 0;
  bit      holding = 1'b0;
  item_t   cur_item;
  int      gap_left = 0;
  int      stall_left = 0;
  bit      long_hold_req = 1'b0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic in_window(logic [31:0] pos);
    logic [31:0] ws;
    logic [31:0] room;
    logic [31:0] wl;
    ws = (win_start < exp_size) ? win_start : exp_size;
    room = exp_size - ws;
    wl = (win_len < room) ? win_len : room;
    return (pos >= ws) && ((pos - ws) < wl);
  endfunction

  function automatic void end_block(logic [2:0] code);
    ended = 1'b1;
    end_status = code;
    phase = P_DONE;
    lit_left = '0;
    match_left = '0;
  endfunction

  function automatic result_t produce_byte(logic [7:0] b);
    result_t r;
    r = '0;
    r.out_valid = in_window(produced);
    r.out_byte = b;
    r.out_position = produced;
    history[wr_ptr] = b;
    wr_ptr = wr_ptr + 16'd1;
    produced = produced + 32'd1;
    return r;
  endfunction

  function automatic logic [2:0] size_check();
    return (produced != exp_size) ? ST_SIZE : ST_OK;
  endfunction

  function automatic result_t decode_step(item_t it);
    result_t r;
    logic    wrong;
    logic [3:0] ln;
    r = '0;
    wrong = 1'b0;
    if (!ended) begin
      if ((it.opcode == OP_TICK) != (phase == P_COPY)) begin
        wrong = 1'b1;
      end else if (it.opcode == OP_TICK) begin
        r = produce_byte(history[wr_ptr - distance]);
        match_left = match_left - 32'd1;
        if (match_left == 0) phase = P_TOKEN;
      end else begin
        case (phase)
          P_TOKEN: begin
            ln = it.in_byte[7:4];
            match_left = {28'd0, it.in_byte[3:0]};
            lit_left = {28'd0, ln};
            if (it.in_last) begin
              if (ln == 0) end_block(size_check()); else end_block(ST_TRUNC);
            end else if (ln == 4'hF) begin
              phase = P_LITEXT;
            end else begin
              phase = (ln != 0) ? P_LITERAL : P_OFF_LO;
            end
          end
          P_LITEXT: begin
            lit_left = sat_add(lit_left, {24'd0, it.in_byte});
            if (it.in_last) end_block(ST_TRUNC);
            else if (it.in_byte != 8'hFF) phase = P_LITERAL;
          end
          P_LITERAL: begin
            r = produce_byte(it.in_byte);
            lit_left = lit_left - 32'd1;
            if (lit_left == 0) begin
              if (it.in_last) end_block(size_check()); else phase = P_OFF_LO;
            end else if (it.in_last) begin
              end_block(ST_TRUNC);
            end
          end
          P_OFF_LO: begin
            distance = {8'd0, it.in_byte};
            if (it.in_last) end_block(ST_TRUNC); else phase = P_OFF_HI;
          end
          P_OFF_HI: begin
            distance[15:8] = it.in_byte;
            if (distance == 0) end_block(ST_ZERO_DIST);
            else if ({16'd0, distance} > produced) end_block(ST_FAR);
            else if (it.in_last) end_block(ST_TRUNC);
            else if (match_left == 32'd15) phase = P_MATCHEXT;
            else begin
              match_left = match_left + 32'd4;
              phase = P_COPY;
            end
          end
          P_MATCHEXT: begin
            match_left = sat_add(match_left, {24'd0, it.in_byte});
            if (it.in_last) end_block(ST_TRUNC);
            else if (it.in_byte != 8'hFF) begin
              match_left = sat_add(match_left, 32'd4);
              phase = P_COPY;
            end
          end
          default: end_block(ST_TRUNC);
        endcase
      end
    end
    r.status = wrong ? ST_OPCODE : end_status;
    r.need_tick = !ended && (phase == P_COPY);
    r.done_res = ended;
    return r;
  endfunction

  // Input driver: one pending item at a time, with a random gap after each transaction.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(decode_step(cur_item));
        holding = 1'b0;
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          holding = 1'b1;
          opcode_i <= cur_item.opcode;
          in_byte_i <= cur_item.in_byte;
          in_last_i <= cur_item.in_last;
        end
      end
      in_valid_i <= holding;
    end
  end

  // Result monitor and receiver stall generation.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      if (res_valid_o && !res_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_valid_o !== e.out_valid) begin
            $error("out_valid: expected %0d, got %0d", e.out_valid, out_valid_o);
            errors++;
          end
          if (out_byte_o !== e.out_byte) begin
            $error("out_byte: expected %0h, got %0h", e.out_byte, out_byte_o);
            errors++;
          end
          if (out_position_o !== e.out_position) begin
            $error("out_position: expected %0d, got %0d", e.out_position, out_position_o);
            errors++;
          end
          if (need_tick_o !== e.need_tick) begin
            $error("need_tick: expected %0d, got %0d", e.need_tick, need_tick_o);
            errors++;
          end
          if (done_res_o !== e.done_res) begin
            $error("done_res: expected %0d, got %0d", e.done_res, done_res_o);
            errors++;
          end
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            errors++;
          end
        end
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) stall_left--;
      res_stall_i <= (stall_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic push_item(logic op, logic [7:0] b, logic last);
    pending_q.push_back(item_t'{opcode: op, in_byte: b, in_last: last});
    items_queued++;
  endtask

  task automatic push_extension(int unsigned rest);
    while (rest >= 255) begin
      push_item(OP_BYTE, 8'hFF, 1'b0);
      rest -= 255;
    end
    push_item(OP_BYTE, rest[7:0], 1'b0);
  endtask

  // Token, extension, literals; if asked, ends block on the last literal or the token.
  task automatic push_literals(int unsigned nlit, logic [3:0] mnib, bit last, bit noise);
    logic [3:0] lnib;
    lnib = (nlit >= 15) ? 4'hF : nlit[3:0];
    if (noise) push_item(OP_TICK, 8'($urandom), 1'($urandom));
    push_item(OP_BYTE, {lnib, mnib}, last && nlit == 0);
    if (lnib == 4'hF) push_extension(nlit - 15);
    for (int unsigned i = 0; i < nlit; i++)
      push_item(OP_BYTE, 8'($urandom), last && (i == nlit - 1));
    decoded_bytes += nlit;
  endtask

  // One full sequence; mlen is at least 4 and the block must hold a byte already.
  task automatic push_sequence(int unsigned nlit, int unsigned mlen, int unsigned copy_dist,
                               bit noise);
    logic [3:0] mnib;
    mnib = (mlen - 4 >= 15) ? 4'hF : 4'(mlen - 4);
    push_literals(nlit, mnib, 1'b0, noise);
    push_item(OP_BYTE, copy_dist[7:0], 1'b0);
    push_item(OP_BYTE, copy_dist[15:8], 1'b0);
    if (mnib == 4'hF) push_extension(mlen - 19);
    for (int unsigned i = 0; i < mlen; i++) begin
      if (noise && $urandom_range(0, 15) == 0)
        push_item(OP_BYTE, 8'($urandom), 1'($urandom));
      push_item(OP_TICK, 8'($urandom), 1'($urandom));
    end
    decoded_bytes += mlen;
  endtask

  task automatic push_random_sequence();
    int unsigned nlit;
    int unsigned mlen;
    int unsigned dmax;
    int unsigned copy_dist;
    nlit = ($urandom_range(0, 30) == 0) ? $urandom_range(265, 290) : $urandom_range(0, 20);
    if (decoded_bytes + nlit == 0) nlit = 1;
    mlen = ($urandom_range(0, 30) == 0) ? $urandom_range(274, 280) : $urandom_range(4, 22);
    dmax = decoded_bytes + nlit;
    if (dmax > 65535) dmax = 65535;
    copy_dist = ($urandom_range(0, 1) == 0) ? $urandom_range(1, (dmax < 8) ? dmax : 8)
                                            : $urandom_range(1, dmax);
    push_sequence(nlit, mlen, copy_dist, $urandom_range(0, 3) == 0);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || holding || expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_EXPECTED_SIZE: exp_size = value;
      CFG_WINDOW_START:  win_start = value;
      default:           win_len = value;
    endcase
  endtask

  function automatic logic [31:0] pick_extreme(logic [31:0] near);
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return near;
      3: return near + $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned kind;
    int unsigned nlit;
    int unsigned copy_dist;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_EXPECTED_SIZE, 32'hFFFF_FFFF);
    write_reg(CFG_WINDOW_START, 32'd2);
    write_reg(CFG_WINDOW_LENGTH, 32'd20);

    // Directed: stray tick, overlapping copy, extended lengths of zero, extreme bytes.
    push_item(OP_TICK, 8'h00, 1'b1);
    push_item(OP_BYTE, 8'h30, 1'b0);
    push_item(OP_BYTE, 8'h00, 1'b0);
    push_item(OP_BYTE, 8'hFF, 1'b0);
    push_item(OP_BYTE, 8'h5A, 1'b0);
    decoded_bytes += 3;
    push_item(OP_BYTE, 8'h01, 1'b0);
    push_item(OP_BYTE, 8'h00, 1'b0);
    for (int i = 0; i < 3; i++) push_item(OP_TICK, 8'hFF, 1'b0);
    // A byte in the middle of a copy is ignored.
    push_item(OP_BYTE, 8'hA5, 1'b1);
    push_item(OP_TICK, 8'h00, 1'b0);
    decoded_bytes += 4;
    push_sequence(15, 19, 7, 1'b0);
    push_sequence(0, 5, 26, 1'b0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_EXPECTED_SIZE, pick_extreme(decoded_bytes + 50));
      write_reg(CFG_WINDOW_START, pick_extreme(decoded_bytes + 10));
      write_reg(CFG_WINDOW_LENGTH, pick_extreme(32'd30));
      if (p == 1) begin
        push_random_sequence();
        long_hold_req = 1'b1;
      end
      while (items_queued < 175 * (p + 1)) begin
        push_random_sequence();
      end
      wait_idle();
    end

    // Final sequence chooses how the block ends.
    kind = $urandom_range(0, 4);
    nlit = $urandom_range(1, 20);
    write_reg(CFG_WINDOW_START, 32'd0);
    write_reg(CFG_WINDOW_LENGTH, 32'hFFFF_FFFF);
    write_reg(CFG_EXPECTED_SIZE,
              decoded_bytes + ((kind == 0) ? nlit : 0) + $urandom_range(0, 1));
    case (kind)
      0: push_literals(nlit, 4'($urandom), 1'b1, 1'b0);
      1: push_literals(0, 4'($urandom), 1'b1, 1'b0);
      2: begin
        push_literals(0, 4'($urandom), 1'b0, 1'b0);
        push_item(OP_BYTE, 8'h00, 1'b0);
        push_item(OP_BYTE, 8'h00, 1'b0);
      end
      3: begin
        copy_dist = (decoded_bytes < 65535) ? decoded_bytes + 1 : 0;
        push_literals(0, 4'($urandom), 1'b0, 1'b0);
        push_item(OP_BYTE, copy_dist[7:0], 1'b0);
        push_item(OP_BYTE, copy_dist[15:8], 1'b0);
      end
      default: push_item(OP_BYTE, {4'($urandom_range(1, 15)), 4'($urandom)}, 1'b1);
    endcase
    // Everything after the end is ignored by the decoder.
    for (int i = 0; i < 8; i++) push_item(1'($urandom), 8'($urandom), 1'($urandom));

    do @(posedge clk_i);
    while (pending_q.size() != 0 || holding || expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
